/* hdl/rgbgp_pkg.sv */
// ----------------------------------------------------------------------------
// rgbgp_pkg
// Shared types and constants of the RGB222 to 2-bit gray row packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbgp_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned ROW_WIDTH_RESET = 144;
  localparam int unsigned ROW_COUNT_RESET = 168;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_ROW_COUNT = 2'd1
  } cfg_idx_e;

  // One queued command: a data byte followed by pad zero bytes.
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
    logic       image_end;
    logic [1:0] pad;
  } cmd_t;

  // (r + g + b) / 3 for a sum of 0..9
  function automatic logic [1:0] gray_of(input logic [3:0] sum);
    logic [1:0] g;
    case (sum) inside
      [4'd0:4'd2]: g = 2'd0;
      [4'd3:4'd5]: g = 2'd1;
      [4'd6:4'd8]: g = 2'd2;
      default:     g = 2'd3;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/rgbgp_ifs.sv */
// ----------------------------------------------------------------------------
// rgbgp_ifs
// Channel interfaces: pixel input, packed byte output, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbgp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rgbgp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       row_end;
  logic       image_end;
  modport source (output valid, output packed_byte, output row_end, output image_end,
                  input ready);
  modport sink   (input valid, input packed_byte, input row_end, input image_end,
                  output ready);
endinterface

interface rgbgp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/rgbgp_front.sv */
// ----------------------------------------------------------------------------
// rgbgp_front
// Accepts pixels, converts to gray, packs slots and issues byte commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgp_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rgbgp_pix_if.sink        pix_i,
  rgbgp_cfg_if.sink        cfg_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output rgbgp_pkg::cmd_t  cmd_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned EW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (EW > rgbgp_pkg::CFG_DATA_W) ? EW : rgbgp_pkg::CFG_DATA_W;
  localparam int unsigned RW   = rgbgp_pkg::ROW_W;
  localparam int unsigned DW   = rgbgp_pkg::CFG_DATA_W;

  logic [DW-1:0]   width_q, count_q;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [5:0]      acc_q, acc_d;
  logic [1:0]      slot_q, slot_d;

  logic [CMPW-1:0] w_ext, w_eff;
  logic [DW-1:0]   c_eff;
  logic            last_col, last_row, accept;
  logic [3:0]      sum;
  logic [1:0]      gray, pad;
  logic [7:0]      byte_v, filled;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && !q_full_i;

  always_comb begin
    w_ext = CMPW'(width_q);
    if (width_q == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (count_q == '0) begin
      c_eff = DW'(1);
    end else if (count_q > DW'(rgbgp_pkg::MAX_ROWS)) begin
      c_eff = DW'(rgbgp_pkg::MAX_ROWS);
    end else begin
      c_eff = count_q;
    end
  end

  assign last_col = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
  assign last_row = (DW'(row_q) + DW'(1)) >= c_eff;

  assign sum    = {2'b00, pix_i.pixel[5:4]} + {2'b00, pix_i.pixel[3:2]}
                + {2'b00, pix_i.pixel[1:0]};
  assign gray   = rgbgp_pkg::gray_of(sum);
  assign byte_v = {2'b00, acc_q} | ({6'b000000, gray} << {slot_q, 1'b0});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      filled[2*k +: 2] = (2'(k) > slot_q) ? gray : byte_v[2*k +: 2];
    end
  end

  // Zero bytes to reach a 4-byte stride per 16 pixels
  assign pad = (w_eff[3:0] == 4'd0) ? 2'd0 : 2'(3'd4 - 3'((w_eff[3:0] + 4'd3) >> 2));

  assign push_o            = accept && (last_col || (slot_q == 2'd3));
  assign cmd_o.packed_byte = last_col ? filled : byte_v;
  assign cmd_o.row_end     = last_col;
  assign cmd_o.image_end   = last_col && last_row;
  assign cmd_o.pad         = last_col ? pad : 2'd0;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    acc_d  = acc_q;
    slot_d = slot_q;
    if (accept) begin
      if (last_col) begin
        col_d  = '0;
        acc_d  = '0;
        slot_d = '0;
        row_d  = last_row ? '0 : RW'(row_q + RW'(1));
      end else begin
        col_d = CW'(col_q + CW'(1));
        if (slot_q == 2'd3) begin
          acc_d  = '0;
          slot_d = '0;
        end else begin
          acc_d  = byte_v[5:0];
          slot_d = slot_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= DW'(rgbgp_pkg::ROW_WIDTH_RESET);
      count_q <= DW'(rgbgp_pkg::ROW_COUNT_RESET);
      col_q   <= '0;
      row_q   <= '0;
      acc_q   <= '0;
      slot_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          rgbgp_pkg::CFG_ROW_WIDTH: width_q <= cfg_i.data;
          rgbgp_pkg::CFG_ROW_COUNT: count_q <= cfg_i.data;
          default: ;
        endcase
      end
      col_q  <= col_d;
      row_q  <= row_d;
      acc_q  <= acc_d;
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/rgbgp_queue.sv */
// ----------------------------------------------------------------------------
// rgbgp_queue
// Two-entry command queue between the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rgbgp_pkg::cmd_t  cmd_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output rgbgp_pkg::cmd_t       cmd_o
);

  localparam int unsigned PW = rgbgp_pkg::QPTR_W;
  localparam int unsigned NW = rgbgp_pkg::QCNT_W;

  rgbgp_pkg::cmd_t entry_q [rgbgp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   cnt_q;

  assign full_o  = (cnt_q == NW'(rgbgp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + NW'(1);
        2'b01:   cnt_q <= cnt_q - NW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/rgbgp_back.sv */
// ----------------------------------------------------------------------------
// rgbgp_back
// Expands each command into data and pad bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire rgbgp_pkg::cmd_t  cmd_i,
  output logic                  pop_o,
  rgbgp_out_if.source           out_o
);

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       row_end_q, image_end_q;
  logic [1:0] k_q;
  logic       load, fin;

  assign load  = q_valid_i && (!out_valid_q || out_o.ready);
  assign fin   = (k_q == cmd_i.pad);
  assign pop_o = load && fin;

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = byte_q;
  assign out_o.row_end     = row_end_q;
  assign out_o.image_end   = image_end_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (k_q == 2'd0) begin
        byte_q      <= cmd_i.packed_byte;
        row_end_q   <= cmd_i.row_end && fin;
        image_end_q <= cmd_i.image_end && fin;
      end else begin
        byte_q      <= 8'h00;
        row_end_q   <= fin;
        image_end_q <= cmd_i.image_end && fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q         <= fin ? 2'd0 : k_q + 2'd1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/rgb222_to_gray2_row_packer.sv */
// ----------------------------------------------------------------------------
// rgb222_to_gray2_row_packer
// Converts RGB222 pixels to 2-bit gray, packs four per byte, pads rows.
// ----------------------------------------------------------------------------
//  channel  dir  transaction                          fields
//  pix_i    in   one source pixel                     pixel[7:0]
//  cfg_i    in   one register write                   index[1:0], data[10:0]
//  out_o    out  one packed byte                      packed_byte, row_end, image_end
//
//  One pixel is taken per cycle while the queue is not full; the back end
//  sends one byte per cycle while out_o.ready is high.
//  A row end with padding sends up to four bytes; the two-entry command
//  queue fills and pix_i.ready drops while the back end catches up.
//  Reset is asynchronous, needs no clearing pass; registers return to
//  width 144 and count 168.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb222_to_gray2_row_packer #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rgbgp_pix_if.sink    pix_i,
  rgbgp_cfg_if.sink    cfg_i,
  rgbgp_out_if.source  out_o
);

  rgbgp_pkg::cmd_t push_cmd, head_cmd;
  logic            push, full, q_valid, pop;

  rgbgp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  rgbgp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  rgbgp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* hdl/rgbgp_checker.sv */
// ----------------------------------------------------------------------------
// rgbgp_checker
// Port-level checks of the row packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_row_end_i,
  input wire logic       out_image_end_i
);

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_image_end_i |-> out_row_end_i)
    else $error("image end without row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(out_row_end_i) && $stable(out_image_end_i))
    else $error("output transaction changed while stalled");

endmodule

bind rgb222_to_gray2_row_packer rgbgp_checker u_rgbgp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.packed_byte),
  .out_row_end_i   (out_o.row_end),
  .out_image_end_i (out_o.image_end)
);

`default_nettype wire
